// ===== design/gcs_pkg.sv =====
package gcs_pkg;

  typedef logic [8:0]  lfsr_t;
  typedef logic [8:0]  chip_t;
  typedef logic [27:0] rate_t;
  typedef logic [17:0] scount_t;

  localparam chip_t   LAST_CHIP    = 9'd510;
  localparam chip_t   SHIFT_WRAP   = 9'd511;
  localparam lfsr_t   LFSR_ONES    = 9'h1FF;
  localparam rate_t   CHIP_RATE_HZ = 28'd511000;
  localparam rate_t   FS_MIN       = 28'd511000;
  localparam rate_t   FS_MAX       = 28'd200000000;
  localparam scount_t SPC_RESET    = 18'd511;

  // floor(y / 125) = (y * RECIP_MULT) >> RECIP_SHIFT, exact for y below 2^25.
  localparam logic [28:0] RECIP_MULT  = 29'd274877907;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = 54;

  localparam logic CFG_IDX_SHIFT = 1'b0;
  localparam logic CFG_IDX_RATE  = 1'b1;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_SHIFT,
    CFG_RATE_MUL,
    CFG_RATE_DIV
  } cfg_state_t;

  typedef struct packed {
    logic    busy;
    rate_t   fs;
    scount_t spc;
    lfsr_t   start;
  } cfg_t;

  function automatic lfsr_t lfsr_step(lfsr_t r);
    return {r[4] ^ r[0], r[8:1]};
  endfunction

endpackage

// ===== design/gcs_cfg.sv =====
module gcs_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [27:0]   cfg_data,
  output gcs_pkg::cfg_t cfg_o
);
  import gcs_pkg::*;

  cfg_state_t        state_r, state_nxt;
  lfsr_t             start_r, start_nxt;
  chip_t             cnt_r, cnt_nxt;
  rate_t             fs_r, fs_nxt;
  scount_t           spc_r, spc_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  rate_t             fs_clamped;

  always_comb begin
    if (cfg_data < FS_MIN) begin
      fs_clamped = FS_MIN;
    end else if (cfg_data > FS_MAX) begin
      fs_clamped = FS_MAX;
    end else begin
      fs_clamped = cfg_data;
    end
  end

  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    fs_nxt    = fs_r;
    spc_nxt   = spc_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      CFG_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == CFG_IDX_SHIFT) begin
            // The start state is stepped from all ones, one chip per cycle.
            start_nxt = LFSR_ONES;
            cnt_nxt   = (cfg_data[8:0] == SHIFT_WRAP) ? '0 : cfg_data[8:0];
            state_nxt = CFG_SHIFT;
          end else begin
            fs_nxt    = fs_clamped;
            state_nxt = CFG_RATE_MUL;
          end
        end
      end
      CFG_SHIFT: begin
        if (cnt_r == '0) begin
          state_nxt = CFG_IDLE;
        end else begin
          start_nxt = lfsr_step(start_r);
          cnt_nxt   = cnt_r - 9'd1;
        end
      end
      CFG_RATE_MUL: begin
        // fs / 1000 = (fs / 8) / 125
        prod_nxt  = PROD_W'(fs_r[27:3]) * PROD_W'(RECIP_MULT);
        state_nxt = CFG_RATE_DIV;
      end
      CFG_RATE_DIV: begin
        spc_nxt   = prod_r[RECIP_SHIFT +: 18];
        state_nxt = CFG_IDLE;
      end
      default: state_nxt = CFG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CFG_IDLE;
      start_r <= LFSR_ONES;
      cnt_r   <= '0;
      fs_r    <= FS_MIN;
      spc_r   <= SPC_RESET;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
      fs_r    <= fs_nxt;
      spc_r   <= spc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign cfg_ready   = (state_r == CFG_IDLE);
  assign cfg_o.busy  = (state_r != CFG_IDLE);
  assign cfg_o.fs    = fs_r;
  assign cfg_o.spc   = spc_r;
  assign cfg_o.start = start_r;

  // A maximal-length register never reaches the all-zero lockup state.
  a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    start_r != '0)
    else $error("start state locked at zero");

  a_spc_range: assert property (@(posedge clk) disable iff (!rst_n)
    spc_r >= 18'd511 && spc_r <= 18'd200000)
    else $error("samples per period out of range");

  a_spc_from_fs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CFG_RATE_DIV |=> (28'(spc_r) * 28'd1000 <= fs_r) &&
                                (fs_r < 28'(spc_r) * 28'd1000 + 28'd1000))
    else $error("samples per period does not match rate");

endmodule

// ===== design/glonass_ca_code_sampler_unit.sv =====
// GLONASS C/A code sampler: each input request yields one sample of the
// 511-chip code, rotated by chip_shift and upsampled to sample_rate_hz, with
// the chip index tracked by an exact integer phase accumulator. Samples flow
// at one per clock when the output is ready and no configuration write is busy,
// through an input register and then a result register. Writing chip_shift
// holds off input requests (shift taken modulo 511) while the rotated start
// state is stepped one chip per cycle; writing sample_rate_hz holds them off
// while the samples-per-period count is derived with a reciprocal multiply.
module glonass_ca_code_sampler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] chip_value, [9:1] chip_position, [15:10] zero
  output logic        out_tlast,  // period_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [27:0] cfg_data
);
  import gcs_pkg::*;

  cfg_t    cfg;

  logic    s1_v_r, s1_restart_r, s1_adv;
  logic    out_v_r, out_value_r, out_last_r;
  chip_t   out_pos_r;

  scount_t sc_r, sc_nxt;
  rate_t   res_r, res_nxt;
  chip_t   chip_r, chip_a, chip_nxt;
  lfsr_t   code_r, code_a, code_nxt;

  logic        start_period, last;
  scount_t     idx;
  logic [28:0] sum, diff;

  gcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !cfg.busy && (!s1_v_r || s1_adv);

  always_comb begin
    start_period = s1_restart_r || (sc_r == '0);
    sum          = {1'b0, res_r} + {1'b0, CHIP_RATE_HZ};
    diff         = sum - {1'b0, cfg.fs};
    idx          = sc_r;
    res_nxt      = res_r;
    chip_a       = chip_r;
    code_a       = code_r;
    if (start_period) begin
      idx     = '0;
      res_nxt = CHIP_RATE_HZ - 28'd1;
      chip_a  = '0;
      code_a  = cfg.start;
    end else if (sum >= {1'b0, cfg.fs}) begin
      // After a rate change the residue may need clamping below fs.
      res_nxt = (diff >= {1'b0, cfg.fs}) ? (cfg.fs - 28'd1) : diff[27:0];
      if (chip_r < LAST_CHIP) begin
        chip_a = chip_r + 9'd1;
        code_a = lfsr_step(code_r);
      end
    end else begin
      res_nxt = sum[27:0];
    end

    last     = (idx >= cfg.spc - 18'd1);
    chip_nxt = chip_a;
    code_nxt = code_a;
    if (last && chip_a < LAST_CHIP) begin
      chip_nxt = chip_a + 9'd1;
      code_nxt = lfsr_step(code_a);
    end
    sc_nxt = last ? '0 : idx + 18'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      sc_r    <= '0;
      res_r   <= '0;
      chip_r  <= '0;
      code_r  <= LFSR_ONES;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
        sc_r    <= sc_nxt;
        res_r   <= res_nxt;
        chip_r  <= chip_nxt;
        code_r  <= code_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_restart_r <= in_tdata[0];
    end
    if (s1_adv) begin
      out_value_r <= code_nxt[2];
      out_pos_r   <= chip_nxt;
      out_last_r  <= last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_pos_r, out_value_r};
  assign out_tlast  = out_last_r;

  a_chip_range: assert property (@(posedge clk) disable iff (!rst_n)
    chip_r <= LAST_CHIP)
    else $error("chip index beyond end of code");

  // A rate change mid-period can end a period early, but the last sample
  // always advances past chip zero.
  a_last_chip: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_last_r |-> out_pos_r != '0)
    else $error("period end on chip zero");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_restart_r |=> out_pos_r == '0 && !out_last_r)
    else $error("restart did not begin at chip zero");

endmodule
